@@ rtl/gbz_pkg.sv @@
// ============================================================================
// gbz_pkg
// Shared sizes, types and the binomial weight table of the 5x5 blur.
// ============================================================================
`default_nettype none

package gbz_pkg;

    // Frame limits
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int KERNEL_SIZE = 5;

    // Field widths fixed by the register map and the stream payload
    localparam int PIX_W        = 8;
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_W        = (CFG_WIDTH_W > CFG_HEIGHT_W) ? CFG_WIDTH_W : CFG_HEIGHT_W;

    // Derived counter widths
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
    localparam int LEAD_W = $clog2(2 * MAX_WIDTH + 3);

    // Line store word: the four rows above the incoming one
    localparam int LINES  = KERNEL_SIZE - 1;
    localparam int LINE_W = LINES * PIX_W;

    // Each axis of the kernel sums to 16, so 4 bits of growth per axis
    localparam int VSUM_W = PIX_W + 4;
    localparam int HSUM_W = PIX_W + 8;

    // Reset values of the size registers, clamped to the frame limits
    localparam int RST_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
    localparam int RST_HEIGHT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;

    // Register indexes
    typedef enum logic [0:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } gbz_cfg_idx_t;

    // Per-item control that rides along the pipeline
    typedef struct packed {
        logic                   res;       // item yields a result
        logic                   last;      // result closes the frame
        logic [KERNEL_SIZE-1:0] col_mask;  // tap l covers column c-2+l inside frame
        logic [KERNEL_SIZE-1:0] row_mask;  // tap k covers row r-2+k inside frame
    } gbz_tag_t;

    // One window column, element KERNEL_SIZE-1 is the newest row
    typedef logic [KERNEL_SIZE-1:0][PIX_W-1:0] gbz_stack_t;

    // Vertical sums of all window columns, indexed by column tap
    typedef logic [KERNEL_SIZE-1:0][VSUM_W-1:0] gbz_vsum_vec_t;

    // Binomial weights 1 4 6 4 1
    function automatic logic [2:0] binom(input int k);
        logic [2:0] w;
        unique case (k)
            0, 4:    w = 3'd1;
            1, 3:    w = 3'd4;
            2:       w = 3'd6;
            default: w = 3'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/gbz_if.sv @@
// ============================================================================
// gbz_if
// Stream channels of the blur: pixel items in, result items out.
// ============================================================================
`default_nettype none

interface gbz_pix_if import gbz_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             command;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output command, output pixel, input ready);
    modport sink   (input valid, input command, input pixel, output ready);
endinterface

interface gbz_res_if import gbz_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] filtered;
    logic             frame_last;

    modport source (output valid, output filtered, output frame_last, input ready);
    modport sink   (input valid, input filtered, input frame_last, output ready);
endinterface

`default_nettype wire

@@ rtl/gbz_ctrl.sv @@
// ============================================================================
// gbz_ctrl
// Size registers, input and output position counters, result scheduling
// and the edge masks of each result.
// ============================================================================
`default_nettype none

module gbz_ctrl import gbz_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire gbz_cfg_idx_t     cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    input  wire logic             fire,
    input  wire logic             command,
    input  wire logic [PIX_W-1:0] pixel,
    output logic                  active,
    output logic [PIX_W-1:0]      pix_eff,
    output logic [COL_W-1:0]      col_addr,
    output gbz_tag_t              tag
);

    logic [WID_W-1:0]  width_reg,  width_next;
    logic [HGT_W-1:0]  height_reg, height_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [HGT_W-1:0]  in_row_reg, in_row_next;
    logic [LEAD_W-1:0] lead_reg,   lead_next;
    logic [COL_W-1:0]  oc_reg,     oc_next;
    logic [HGT_W-1:0]  orow_reg,   orow_next;

    logic              frame_open;
    logic              col_end;
    logic [LEAD_W-1:0] lag;
    logic              res;
    logic              last;
    logic              oc_end;
    logic [WID_W:0]    oc_w, wd_w;
    logic [HGT_W:0]    or_w, hd_w;
    logic [KERNEL_SIZE-1:0] col_mask, row_mask;

    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_WIDTH_W-1:0] v);
        logic [WID_W-1:0] r;
        if (v == '0)
            r = WID_W'(1);
        else if (32'(v) > MAX_WIDTH)
            r = WID_W'(MAX_WIDTH);
        else
            r = WID_W'(v);
        return r;
    endfunction

    function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_HEIGHT_W-1:0] v);
        logic [HGT_W-1:0] r;
        if (v == '0)
            r = HGT_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            r = HGT_W'(MAX_HEIGHT);
        else
            r = HGT_W'(v);
        return r;
    endfunction

    // Item classification and tag
    always_comb
    begin
        frame_open = in_row_reg < height_reg;
        active     = frame_open ? !command : 1'b1;
        pix_eff    = frame_open ? pixel : '0;
        col_addr   = in_col_reg;
        col_end    = (WID_W'(in_col_reg) + WID_W'(1)) >= width_reg;

        // results start once two rows and two pixels are in
        lag = LEAD_W'({width_reg, 1'b0}) + LEAD_W'(2);
        res = lead_reg == lag;

        oc_w = (WID_W + 1)'(oc_reg);
        wd_w = (WID_W + 1)'(width_reg);
        or_w = (HGT_W + 1)'(orow_reg);
        hd_w = (HGT_W + 1)'(height_reg);

        col_mask[0] = oc_reg >= COL_W'(2);
        col_mask[1] = oc_reg != '0;
        col_mask[2] = 1'b1;
        col_mask[3] = (oc_w + (WID_W + 1)'(1)) < wd_w;
        col_mask[4] = (oc_w + (WID_W + 1)'(2)) < wd_w;

        row_mask[0] = or_w >= (HGT_W + 1)'(2);
        row_mask[1] = orow_reg != '0;
        row_mask[2] = 1'b1;
        row_mask[3] = (or_w + (HGT_W + 1)'(1)) < hd_w;
        row_mask[4] = (or_w + (HGT_W + 1)'(2)) < hd_w;

        oc_end = (oc_w + (WID_W + 1)'(1)) == wd_w;
        last   = oc_end && ((or_w + (HGT_W + 1)'(1)) == hd_w);

        tag.res      = res;
        tag.last     = last;
        tag.col_mask = col_mask;
        tag.row_mask = row_mask;
    end

    // Next state of registers and counters
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        lead_next   = lead_reg;
        oc_next     = oc_reg;
        orow_next   = orow_reg;

        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_next  = clamp_width(cfg_data[CFG_WIDTH_W-1:0]);
                CFG_IMAGE_HEIGHT: height_next = clamp_height(cfg_data[CFG_HEIGHT_W-1:0]);
            endcase
            in_col_next = '0;
            in_row_next = '0;
            lead_next   = '0;
            oc_next     = '0;
            orow_next   = '0;
        end
        else if (fire && active)
        begin
            // input position keeps wrapping through the flush rows
            if (col_end)
            begin
                in_col_next = '0;
                if (frame_open)
                    in_row_next = in_row_reg + HGT_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end

            if (!res)
            begin
                lead_next = lead_reg + LEAD_W'(1);
            end
            else if (last)
            begin
                in_col_next = '0;
                in_row_next = '0;
                lead_next   = '0;
                oc_next     = '0;
                orow_next   = '0;
            end
            else if (oc_end)
            begin
                oc_next   = '0;
                orow_next = orow_reg + HGT_W'(1);
            end
            else
            begin
                oc_next = oc_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WID_W'(RST_WIDTH);
            height_reg <= HGT_W'(RST_HEIGHT);
            in_col_reg <= '0;
            in_row_reg <= '0;
            lead_reg   <= '0;
            oc_reg     <= '0;
            orow_reg   <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            lead_reg   <= lead_next;
            oc_reg     <= oc_next;
            orow_reg   <= orow_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gbz_line_store.sv @@
// ============================================================================
// gbz_line_store
// Four-row line memory, one word per column, and the first pipeline stage.
// Each item reads the rows above its column and writes back the shifted word.
// ============================================================================
`default_nettype none

module gbz_line_store import gbz_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire logic [PIX_W-1:0] pix_in,
    input  wire logic [COL_W-1:0] col_in,
    input  wire gbz_tag_t         tag_in,
    input  wire logic             adv,
    output logic                  val,
    output gbz_tag_t              tag,
    output gbz_stack_t            stack
);

    logic [LINE_W-1:0] mem [MAX_WIDTH];

    logic              val_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [COL_W-1:0]  col_reg;
    gbz_tag_t          tag_reg;
    logic [LINE_W-1:0] rd_reg;
    logic              byp_reg;
    logic [LINE_W-1:0] byp_data_reg;

    logic [LINE_W-1:0] rd_eff;
    logic [LINE_W-1:0] wr_data;

    // Write of the leaving item may land on the column being read
    always_comb
    begin
        rd_eff  = byp_reg ? byp_data_reg : rd_reg;
        wr_data = {rd_eff[LINE_W-PIX_W-1:0], pix_reg};
        stack[KERNEL_SIZE-1] = pix_reg;
        for (int k = 0; k < LINES; k++)
        begin
            stack[KERNEL_SIZE-2-k] = rd_eff[k*PIX_W +: PIX_W];
        end
    end

    // Line memory
    always_ff @(posedge clk)
    begin
        if (adv)
            mem[col_reg] <= wr_data;
        if (load)
            rd_reg <= mem[col_in];
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pix_reg      <= pix_in;
            col_reg      <= col_in;
            tag_reg      <= tag_in;
            byp_data_reg <= wr_data;
        end
    end

    // Stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= 1'b0;
            byp_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                val_reg <= 1'b1;
                byp_reg <= adv && (col_reg == col_in);
            end
            else if (adv)
            begin
                val_reg <= 1'b0;
            end
        end
    end

    assign val = val_reg;
    assign tag = tag_reg;

endmodule

`default_nettype wire

@@ rtl/gbz_col_cell.sv @@
// ============================================================================
// gbz_col_cell
// One window column: holds a five-row stack, hands it to the next cell on
// each shift and forms the row-masked vertical binomial sum.
// ============================================================================
`default_nettype none

module gbz_col_cell import gbz_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   shift_en,
    input  wire gbz_stack_t             stack_in,
    input  wire logic                   sum_en,
    input  wire logic [KERNEL_SIZE-1:0] row_mask,
    output gbz_stack_t                  stack_out,
    output logic [VSUM_W-1:0]           vsum
);

    gbz_stack_t        stack_reg;
    logic [VSUM_W-1:0] vsum_reg, vsum_next;

    // Vertical weighted sum, rows outside the frame count as zero
    always_comb
    begin
        vsum_next = '0;
        for (int k = 0; k < KERNEL_SIZE; k++)
        begin
            if (row_mask[k])
                vsum_next = vsum_next + VSUM_W'(stack_reg[k]) * VSUM_W'(binom(k));
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
            stack_reg <= stack_in;
        if (sum_en)
            vsum_reg <= vsum_next;
    end

    assign stack_out = stack_reg;
    assign vsum      = vsum_reg;

endmodule

`default_nettype wire

@@ rtl/gbz_hsum.sv @@
// ============================================================================
// gbz_hsum
// Horizontal binomial sum over the column sums and the result register.
// ============================================================================
`default_nettype none

module gbz_hsum import gbz_pkg::*; (
    input  wire logic                   clk,
    input  wire logic                   load,
    input  wire gbz_vsum_vec_t          vsum,
    input  wire logic [KERNEL_SIZE-1:0] col_mask,
    output logic [PIX_W-1:0]            filtered
);

    logic [HSUM_W-1:0] acc;
    logic [PIX_W-1:0]  filtered_reg, filtered_next;

    // Columns outside the frame count as zero; divide by 256 by dropping bits
    always_comb
    begin
        acc = '0;
        for (int l = 0; l < KERNEL_SIZE; l++)
        begin
            if (col_mask[l])
                acc = acc + HSUM_W'(vsum[l]) * HSUM_W'(binom(l));
        end
        filtered_next = acc[HSUM_W-1 -: PIX_W];
    end

    always_ff @(posedge clk)
    begin
        if (load)
            filtered_reg <= filtered_next;
    end

    assign filtered = filtered_reg;

endmodule

`default_nettype wire

@@ rtl/gaussian_blur_5x5_zero_pad.sv @@
// ============================================================================
// gaussian_blur_5x5_zero_pad
// 5x5 binomial blur of a grey raster stream with zero taps outside the frame.
// ============================================================================
// Usage:
//   pixel_stream carries items {command, pixel} in raster order; command 0
//   is a frame pixel, command 1 a flush item. result_stream carries
//   {filtered, frame_last}. Frame size is set through cfg_wr_en / cfg_index /
//   cfg_data while the block is idle; any write restarts the frame.
//   A result is the pixel two rows and two columns behind the stream, so
//   the first 2*width+2 items give none; after the last frame pixel the
//   same number of flush items drain the frame, frame_last marking the end.
//   Flush items sent before the frame is complete are taken and dropped.
// Throughput and pipeline:
//   One item per clock while result_stream is not stalled. The line store
//   has one read and one write per item and the window is a row of five
//   column cells that shift once per item. The item causing a result
//   goes through the line read, window shift, column sums, then row sum
//   into the output register, where the result is valid.
// Reset and stalls:
//   Reset empties the pipeline and sets width and height to 1024. The line
//   memory is not cleared: taps from rows not yet written are masked.
//   When result_stream stalls, the four stages fill up before ready drops.
// ============================================================================
`default_nettype none

module gaussian_blur_5x5_zero_pad import gbz_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire gbz_cfg_idx_t     cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data,
    gbz_pix_if.sink               pixel_stream,
    gbz_res_if.source             result_stream
);

    logic             fire;
    logic             active;
    logic [PIX_W-1:0] pix_eff;
    logic [COL_W-1:0] col_addr;
    gbz_tag_t         tag_in;

    logic             load_a;
    logic             val_a;
    gbz_tag_t         tag_a;
    gbz_stack_t       stack_a;

    logic             ready_a, ready_b, ready_c, ready_o;
    logic             adv_a, adv_b, adv_c;

    logic             val_b_reg;
    gbz_tag_t         tag_b_reg;
    logic             val_c_reg;
    logic [KERNEL_SIZE-1:0] col_mask_c_reg;
    logic             last_c_reg;
    logic             out_valid_reg;
    logic             last_out_reg;

    gbz_stack_t        cell_stack [KERNEL_SIZE];
    logic [VSUM_W-1:0] cell_vsum  [KERNEL_SIZE];
    gbz_vsum_vec_t     vsum_taps;

    // Stage handshake, ready ripples back from the output register
    assign ready_o = !out_valid_reg || result_stream.ready;
    assign adv_c   = val_c_reg && ready_o;
    assign ready_c = !val_c_reg || adv_c;
    assign adv_b   = val_b_reg && ready_c;
    assign ready_b = !val_b_reg || adv_b;
    assign adv_a   = val_a && ready_b;
    assign ready_a = !val_a || adv_a;

    assign pixel_stream.ready = ready_a;
    assign fire   = pixel_stream.valid && ready_a;
    assign load_a = fire && active;

    gbz_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .command   (pixel_stream.command),
        .pixel     (pixel_stream.pixel),
        .active    (active),
        .pix_eff   (pix_eff),
        .col_addr  (col_addr),
        .tag       (tag_in)
    );

    gbz_line_store u_line_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load_a),
        .pix_in (pix_eff),
        .col_in (col_addr),
        .tag_in (tag_in),
        .adv    (adv_a),
        .val    (val_a),
        .tag    (tag_a),
        .stack  (stack_a)
    );

    // Window: cell 0 takes the newest column, the last cell the oldest
    for (genvar i = 0; i < KERNEL_SIZE; i++)
    begin : g_cell
        gbz_stack_t cell_in;
        if (i == 0)
        begin : g_head
            assign cell_in = stack_a;
        end
        else
        begin : g_link
            assign cell_in = cell_stack[i-1];
        end

        gbz_col_cell u_cell (
            .clk       (clk),
            .shift_en  (adv_a),
            .stack_in  (cell_in),
            .sum_en    (adv_b),
            .row_mask  (tag_b_reg.row_mask),
            .stack_out (cell_stack[i]),
            .vsum      (cell_vsum[i])
        );

        assign vsum_taps[KERNEL_SIZE-1-i] = cell_vsum[i];
    end

    gbz_hsum u_hsum (
        .clk      (clk),
        .load     (adv_c),
        .vsum     (vsum_taps),
        .col_mask (col_mask_c_reg),
        .filtered (result_stream.filtered)
    );

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv_a)
            tag_b_reg <= tag_a;
        if (adv_b)
        begin
            col_mask_c_reg <= tag_b_reg.col_mask;
            last_c_reg     <= tag_b_reg.last;
        end
        if (adv_c)
            last_out_reg <= last_c_reg;
    end

    // Stage valids, only result items go past the window
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_b_reg     <= 1'b0;
            val_c_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_a)
                val_b_reg <= tag_a.res;
            else if (adv_b)
                val_b_reg <= 1'b0;

            if (adv_b)
                val_c_reg <= 1'b1;
            else if (adv_c)
                val_c_reg <= 1'b0;

            if (adv_c)
                out_valid_reg <= 1'b1;
            else if (result_stream.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign result_stream.valid      = out_valid_reg;
    assign result_stream.frame_last = last_out_reg;

    // Checks
    a_c_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv_c |=> out_valid_reg)
        else $error("result left stage C but output register is empty");

    a_window_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (val_b_reg && !ready_c) |-> !adv_a)
        else $error("window shifted under a stalled result");

    a_center_tap: assert property (@(posedge clk) disable iff (!rst_n)
        val_b_reg |-> (tag_b_reg.res && tag_b_reg.row_mask[2] && tag_b_reg.col_mask[2]))
        else $error("result in window stage without center tap");

endmodule

`default_nettype wire

@@ sim/tb_gaussian_blur_5x5_zero_pad.sv @@
// ============================================================================
// tb_gaussian_blur_5x5_zero_pad
// Self-checking bench for the 5x5 binomial blur with zero padding.
// ============================================================================
// Pixel items go through random source gaps and result items meet random
// sink stalls. A bit-exact blur model runs on every accepted item and
// queues the expected results, which are compared in order. Directed
// frames come first: flat white and black images, zero sizes, dropped
// width bits and a clamped height, flush items before the frame end, pixels
// after the frame end, and a restart in mid-frame. Many small random frames
// follow.
// ============================================================================
`default_nettype none

module tb_gaussian_blur_5x5_zero_pad import gbz_pkg::*; ();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ROW_SLOTS    = 8;
    localparam int unsigned IDLE_PCT     = 34;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned RAND_ITEMS   = 1350;

    // Item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum int unsigned {
        PAT_RANDOM,
        PAT_WHITE,
        PAT_BLACK,
        PAT_SPECKLE
    } pix_pattern_t;

    typedef struct packed {
        logic [PIX_W-1:0] filtered;
        logic             frame_last;
    } blur_result_t;

    // ------------------------------------------------------------------------
    // Blur model and result store
    // ------------------------------------------------------------------------
    class blur_checker;
        int unsigned      width;
        int unsigned      height;
        logic [PIX_W-1:0] rows [ROW_SLOTS][MAX_WIDTH];
        int unsigned      in_col;
        int unsigned      in_row;
        int unsigned      out_count;
        int unsigned      taken;
        int unsigned      taps [KERNEL_SIZE];
        blur_result_t     waiting [$];
        int unsigned      errors;
        int unsigned      checked;
        int unsigned      frames_closed;
        int unsigned      used_items;

        function new();
            taps   = '{1, 4, 6, 4, 1};
            width  = RST_WIDTH;
            height = RST_HEIGHT;
            foreach (rows[s, c])
                rows[s][c] = '0;
            errors        = 0;
            checked       = 0;
            frames_closed = 0;
            used_items    = 0;
            restart();
        endfunction

        function void restart();
            in_col    = 0;
            in_row    = 0;
            out_count = 0;
            taken     = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned limit);
            if (v == 0)
                return 1;
            if (v > limit)
                return limit;
            return v;
        endfunction

        // Any size write restarts the frame
        function void set_size(gbz_cfg_idx_t idx, logic [CFG_W-1:0] data);
            if (idx == CFG_IMAGE_WIDTH)
                width = clamp_size(data[CFG_WIDTH_W-1:0], MAX_WIDTH);
            else
                height = clamp_size(data[CFG_HEIGHT_W-1:0], MAX_HEIGHT);
            restart();
        endfunction

        function bit filling();
            return in_row < height;
        endfunction

        function int unsigned pending();
            return waiting.size();
        endfunction

        // Weighted 5x5 neighborhood of (r, c), taps outside the frame are zero
        function logic [PIX_W-1:0] window_sum(int unsigned r, int unsigned c);
            int          rr;
            int          cc;
            int unsigned acc;
            acc = 0;
            for (int k = 0; k < KERNEL_SIZE; k++)
            begin
                rr = int'(r) + k - 2;
                if (rr < 0 || rr >= int'(height))
                    continue;
                for (int l = 0; l < KERNEL_SIZE; l++)
                begin
                    cc = int'(c) + l - 2;
                    if (cc < 0 || cc >= int'(width))
                        continue;
                    acc += taps[k] * taps[l] * rows[rr % ROW_SLOTS][cc];
                end
            end
            return PIX_W'(acc >> 8);
        endfunction

        // Accepted input item: update the model, queue a result if one is due
        function void take_item(logic cmd, logic [PIX_W-1:0] px);
            int unsigned  total;
            int unsigned  lag;
            blur_result_t res;
            total = width * height;
            lag   = 2 * width + 2;
            if (in_row < height)
            begin
                // flush items before the frame is complete are dropped
                if (cmd == CMD_FLUSH)
                    return;
                rows[in_row % ROW_SLOTS][in_col] = px;
                in_col++;
                if (in_col >= width)
                begin
                    in_col = 0;
                    in_row++;
                end
            end
            taken++;
            used_items++;
            if (out_count >= total || taken <= out_count + lag)
                return;
            res.filtered = window_sum(out_count / width, out_count % width);
            out_count++;
            res.frame_last = (out_count >= total);
            if (res.frame_last)
            begin
                restart();
                frames_closed++;
            end
            waiting.push_back(res);
        endfunction

        function void check_result(logic [PIX_W-1:0] filtered, logic frame_last);
            blur_result_t want;
            checked++;
            if (waiting.size() == 0)
            begin
                errors++;
                $error("unexpected result item: filtered %0d, frame_last %0b",
                       filtered, frame_last);
                return;
            end
            want = waiting.pop_front();
            if (filtered !== want.filtered)
            begin
                errors++;
                $error("filtered: expected %0d, actual %0d", want.filtered, filtered);
            end
            if (frame_last !== want.frame_last)
            begin
                errors++;
                $error("frame_last: expected %0b, actual %0b",
                       want.frame_last, frame_last);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels and the block
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    gbz_cfg_idx_t     cfg_index;
    logic [CFG_W-1:0] cfg_data;
    bit               src_idle_on  = 1'b1;
    bit               sink_idle_on = 1'b1;
    blur_checker      sb = new();

    gbz_pix_if pix_if ();
    gbz_res_if res_if ();

    always #6 clk = ~clk;

    gaussian_blur_5x5_zero_pad u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .pixel_stream  (pix_if),
        .result_stream (res_if)
    );

    // ------------------------------------------------------------------------
    // Result sink: random stalls, every accepted item is checked
    // ------------------------------------------------------------------------
    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
                sb.check_result(res_if.filtered, res_if.frame_last);
            res_if.ready <= !sink_idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run after too long without any accepted item
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned stall_cycles;
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((pix_if.valid && pix_if.ready) || (res_if.valid && res_if.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------
    function automatic logic [PIX_W-1:0] pick_pixel(pix_pattern_t pat);
        case (pat)
            PAT_WHITE:   return '1;
            PAT_BLACK:   return '0;
            PAT_SPECKLE:
            begin
                case ($urandom_range(2))
                    0:       return '0;
                    1:       return '1;
                    default: return PIX_W'($urandom);
                endcase
            end
            default:     return PIX_W'($urandom);
        endcase
    endfunction

    // One item with a random gap ahead of it, modeled once accepted
    task automatic send_item(logic cmd, logic [PIX_W-1:0] px);
        while (src_idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid   <= 1'b1;
        pix_if.command <= cmd;
        pix_if.pixel   <= px;
        do
            @(posedge clk);
        while (!pix_if.ready);
        sb.take_item(cmd, px);
    endtask

    // Size write, only once the block has drained
    task automatic write_size(gbz_cfg_idx_t idx, logic [CFG_W-1:0] data);
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.set_size(idx, data);
    endtask

    // Full frame plus flush; noise_pct drops flush items into the frame,
    // late_pct sends pixels in place of flush items after the frame end
    task automatic run_frame(pix_pattern_t pat, int unsigned noise_pct,
                             int unsigned late_pct);
        int unsigned start_frames;
        start_frames = sb.frames_closed;
        while (sb.frames_closed == start_frames)
        begin
            if (sb.filling())
            begin
                if ($urandom_range(99) < noise_pct)
                    send_item(CMD_FLUSH, PIX_W'($urandom));
                else
                    send_item(CMD_PIXEL, pick_pixel(pat));
            end
            else if ($urandom_range(99) < late_pct)
                send_item(CMD_PIXEL, PIX_W'($urandom));
            else
                send_item(CMD_FLUSH, PIX_W'($urandom));
        end
    endtask

    // Part of a frame, then a size write that restarts it
    task automatic run_partial(int unsigned n);
        repeat (n) send_item(CMD_PIXEL, pick_pixel(PAT_RANDOM));
        write_size(CFG_IMAGE_WIDTH, CFG_W'(sb.width));
    endtask

    // Flush items the block takes and drops
    task automatic send_ignored(int unsigned n);
        repeat (n) send_item(CMD_FLUSH, PIX_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned      rand_start;
        int unsigned      used;
        int unsigned      total;
        logic [CFG_W-1:0] wdata;
        logic [CFG_W-1:0] hdata;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= CFG_IMAGE_WIDTH;
        cfg_data       <= '0;
        pix_if.valid   <= 1'b0;
        pix_if.command <= CMD_PIXEL;
        pix_if.pixel   <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // 5x5 frames: flat white, flat black, speckle; white and speckle with noise both sides
        write_size(CFG_IMAGE_WIDTH, CFG_W'(5));
        write_size(CFG_IMAGE_HEIGHT, CFG_W'(5));
        send_ignored(3);
        run_frame(PAT_WHITE, 15, 30);
        run_frame(PAT_BLACK, 0, 0);
        send_ignored(2);
        run_frame(PAT_SPECKLE, 10, 50);

        // zero sizes read as one
        write_size(CFG_IMAGE_WIDTH, CFG_W'(0));
        write_size(CFG_IMAGE_HEIGHT, CFG_W'(0));
        run_frame(PAT_WHITE, 0, 0);

        // width bits above the field are dropped; height above the limit
        // clamps, checked over the first rows of the tall frame
        write_size(CFG_IMAGE_WIDTH, 13'h1803);
        write_size(CFG_IMAGE_HEIGHT, 13'h1FFF);
        run_partial(40);

        // restart in mid-frame, after some results have come out
        write_size(CFG_IMAGE_WIDTH, CFG_W'(7));
        write_size(CFG_IMAGE_HEIGHT, CFG_W'(6));
        run_partial(30);
        run_frame(PAT_RANDOM, 5, 20);

        // random frames, mostly small; no idling in the middle stretch
        rand_start = sb.used_items;
        while (sb.used_items - rand_start < RAND_ITEMS)
        begin
            used         = sb.used_items - rand_start;
            src_idle_on  = !(used >= 500 && used < 900);
            sink_idle_on = src_idle_on;

            if ($urandom_range(99) < 40)
            begin
                case ($urandom_range(39))
                    0, 1:    wdata = '0;
                    2, 3, 4: wdata = {2'($urandom_range(1, 3)), 11'($urandom_range(1, 16))};
                    5:       wdata = CFG_W'($urandom_range(17, 64));
                    default: wdata = CFG_W'($urandom_range(1, 16));
                endcase
                hdata = ($urandom_range(19) == 0) ? '0 : CFG_W'($urandom_range(1, 12));
                if ($urandom_range(1))
                    write_size(CFG_IMAGE_WIDTH, wdata);
                if ($urandom_range(1))
                    write_size(CFG_IMAGE_HEIGHT, hdata);
                // keep wide frames short
                if (sb.width * sb.height > 3000)
                    write_size(CFG_IMAGE_HEIGHT, CFG_W'($urandom_range(1, 2)));
            end

            total = sb.width * sb.height;
            if (total > 1 && $urandom_range(99) < 4)
                run_partial($urandom_range(1, total - 1));
            else
                run_frame(pix_pattern_t'($urandom_range(3)), 8, 20);

            if ($urandom_range(99) < 15)
                send_ignored($urandom_range(1, 3));
        end

        // drain
        pix_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d frames, %0d pixel and flush items, %0d results checked",
                 sb.frames_closed, sb.used_items, sb.checked);
        $display("sizes from 1x1 up to 64 wide, zero sizes, a clamped height, restarts");
        if (sb.errors == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
